// File: rtl/core/fir_decimator_assert.svh
// Assertion macros for the decimator; clk and rst_n come from the including scope.
`ifndef FIR_DECIMATOR_ASSERT_SVH
`define FIR_DECIMATOR_ASSERT_SVH

// Same-cycle implication.
`define FIRD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FIRD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fird_pkg.sv
package fird_pkg;

    localparam int IDX_W = 7;
    localparam int DF_W  = 4;
    localparam int TPP_W = 5;

    localparam int DEF_MAX_DECIM    = 8;
    localparam int DEF_MAX_TAPS     = 16;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_COEF_WIDTH   = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [DF_W-1:0]  DF_RESET  = 4'd2;
    localparam logic [TPP_W-1:0] TPP_RESET = 5'd16;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef enum logic {
        REG_DECIM = 1'b0,
        REG_TAPS  = 1'b1
    } fird_reg_t;

    typedef struct packed {
        logic [DF_W-1:0]  decim_factor;
        logic [TPP_W-1:0] taps_per_phase;
    } fird_cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fird_qstat_t;

    typedef struct packed {
        logic idle;
        logic finishing;
    } fird_bstat_t;

    // Zero acts as one, anything above the limit acts as the limit.
    function automatic logic [31:0] fird_clamp(input logic [31:0] v, input logic [31:0] maxv);
        logic [31:0] r;
        r = v;
        if (v == 32'd0)
        begin
            r = 32'd1;
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/fird_queue.sv
module fird_queue
    import fird_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fird_qstat_t      qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_data    = slot_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/fird_front.sv
module fird_front
    import fird_pkg::*;
#(
    parameter int MAX_DECIM    = DEF_MAX_DECIM,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int CMD_W        = DEF_SAMPLE_WIDTH + IDX_W + DEF_COEF_WIDTH + 2
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fird_cfg_t                             cfg,
    input  logic                                  in_valid,
    input  logic                                  in_req,
    input  logic [SAMPLE_WIDTH+IDX_W+COEF_WIDTH-1:0] in_data,
    output logic                                  in_ready,
    input  fird_qstat_t                           qstat,
    output logic                                  push,
    output logic [CMD_W-1:0]                      push_data
);

    localparam int PH_W = $clog2(MAX_DECIM);

    logic [PH_W-1:0] phase_reg, phase_next;
    logic [31:0]     d_eff;
    logic            accept;
    logic            is_sample;
    logic            emit;

    assign in_ready  = !qstat.full;
    assign accept    = in_valid && in_ready;
    assign is_sample = (in_req == REQ_SAMPLE);
    assign d_eff     = fird_clamp(32'(cfg.decim_factor), 32'(MAX_DECIM));
    assign emit      = (32'(phase_reg) + 32'd1 >= d_eff);

    assign push      = accept;
    assign push_data = {emit && is_sample, in_req, in_data};

    always_comb
    begin
        phase_next = phase_reg;
        if (accept && is_sample)
        begin
            phase_next = emit ? '0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: rtl/core/fird_back.sv
module fird_back
    import fird_pkg::*;
#(
    parameter int MAX_DECIM          = DEF_MAX_DECIM,
    parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH       = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH         = DEF_COEF_WIDTH,
    parameter int CMD_W              = DEF_SAMPLE_WIDTH + IDX_W + DEF_COEF_WIDTH + 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fird_cfg_t               cfg,
    input  logic                    q_valid,
    input  logic [CMD_W-1:0]        q_data,
    output logic                    q_pop,
    output fird_bstat_t             bstat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0] out_sample,
    output logic                    out_sat
);

    localparam int DEPTH   = MAX_DECIM * MAX_TAPS_PER_PHASE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int DW      = $clog2(MAX_DECIM + 1);
    localparam int TW      = $clog2(MAX_TAPS_PER_PHASE + 1);
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_RAW = PROD_W + ADDR_W + 1;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(64'sd1 <<< (COEF_WIDTH - 2));
    localparam logic signed [ACC_W-1:0] HI_V = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] LO_V = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic [SAMPLE_WIDTH-1:0] OUT_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] OUT_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_DONE = 3'b100
    } fird_state_t;

    fird_state_t state_reg, state_next;

    // command fields
    logic signed [SAMPLE_WIDTH-1:0] c_sample;
    logic [IDX_W-1:0]               c_idx;
    logic signed [COEF_WIDTH-1:0]   c_coef;
    logic                           c_is_coef;
    logic                           c_emit;
    logic [31:0]                    idx_ext;
    logic [ADDR_W-1:0]              c_addr;
    logic                           idx_ok;

    // window length
    logic [31:0]       d_eff, t_eff;
    logic [DW-1:0]     d_n;
    logic [TW-1:0]     t_n;
    logic [DW+TW-1:0]  len_wide;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  len_m1;

    // storage
    logic signed [COEF_WIDTH-1:0]   coef_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [DEPTH];
    logic [DEPTH-1:0]               coef_vld_reg;

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] m_reg, m_next;
    logic [ADDR_W-1:0] age_reg, age_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next, rd_ptr_inc;
    logic [LEN_W:0]    nw_e, len_e, start_w;
    logic [ADDR_W-1:0] start_ptr;

    // MAC pipeline
    logic                            s1_vld_reg, s2_vld_reg;
    logic                            coef_ok_reg, hist_ok_reg;
    logic signed [COEF_WIDTH-1:0]    coef_rd_reg, c_op;
    logic signed [SAMPLE_WIDTH-1:0]  hist_rd_reg, h_op;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [ACC_W-1:0]         rnd_sum, rnd_sh;
    logic                            sat_hi, sat_lo;

    logic do_coef, do_push, start_mac, issue, hist_ok, pipe_empty, out_free, finish;
    logic out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                    out_sat_reg;

    assign c_sample  = q_data[SAMPLE_WIDTH-1:0];
    assign c_idx     = q_data[SAMPLE_WIDTH+IDX_W-1:SAMPLE_WIDTH];
    assign c_coef    = q_data[SAMPLE_WIDTH+IDX_W+COEF_WIDTH-1:SAMPLE_WIDTH+IDX_W];
    assign c_is_coef = (q_data[CMD_W-2] == REQ_COEF);
    assign c_emit    = q_data[CMD_W-1];
    assign idx_ext   = 32'(c_idx);
    assign c_addr    = idx_ext[ADDR_W-1:0];
    assign idx_ok    = (idx_ext < 32'(DEPTH));

    assign d_eff    = fird_clamp(32'(cfg.decim_factor), 32'(MAX_DECIM));
    assign t_eff    = fird_clamp(32'(cfg.taps_per_phase), 32'(MAX_TAPS_PER_PHASE));
    assign d_n      = d_eff[DW-1:0];
    assign t_n      = t_eff[TW-1:0];
    assign len_wide = d_n * t_n;
    assign len      = len_wide[LEN_W-1:0];
    assign len_m1   = len - 1'b1;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign do_coef   = q_pop && c_is_coef && idx_ok;
    assign do_push   = q_pop && !c_is_coef;
    assign start_mac = do_push && c_emit;
    assign issue     = (state_reg == ST_MAC);

    assign wr_ptr_inc = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // oldest window entry sits len places behind the write pointer, modulo the depth
    assign nw_e      = (LEN_W+1)'(wr_ptr_inc);
    assign len_e     = (LEN_W+1)'(len);
    assign start_w   = (nw_e >= len_e) ? nw_e - len_e : nw_e + (LEN_W+1)'(DEPTH) - len_e;
    assign start_ptr = start_w[ADDR_W-1:0];

    // entries older than the fill count were never pushed and read as zero
    assign hist_ok    = ((LEN_W)'(age_reg) < fill_reg);
    assign pipe_empty = !s1_vld_reg && !s2_vld_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign finish     = (state_reg == ST_DONE) && pipe_empty && out_free;

    assign c_op = coef_ok_reg ? coef_rd_reg : '0;
    assign h_op = hist_ok_reg ? hist_rd_reg : '0;

    assign rnd_sum = acc_reg + RND;
    assign rnd_sh  = rnd_sum >>> (COEF_WIDTH - 1);
    assign sat_hi  = (rnd_sh > HI_V);
    assign sat_lo  = (rnd_sh < LO_V);

    assign bstat.idle      = (state_reg == ST_IDLE);
    assign bstat.finishing = (state_reg == ST_DONE);

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_sat    = out_sat_reg;

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        age_next    = age_reg;
        rd_ptr_next = rd_ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_mac)
                begin
                    state_next  = ST_MAC;
                    m_next      = '0;
                    age_next    = len_m1[ADDR_W-1:0];
                    rd_ptr_next = start_ptr;
                end
            end
            ST_MAC:
            begin
                m_next      = m_reg + 1'b1;
                age_next    = age_reg - 1'b1;
                rd_ptr_next = rd_ptr_inc;
                if (age_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_inc;
            if (fill_reg != LEN_W'(DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_coef)
        begin
            coef_mem[c_addr] <= c_coef;
        end
        if (do_push)
        begin
            hist_mem[wr_ptr_reg] <= c_sample;
        end
        if (issue)
        begin
            coef_rd_reg <= coef_mem[m_reg];
            hist_rd_reg <= hist_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= c_op * h_op;
        if (start_mac)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (finish)
        begin
            out_sample_reg <= sat_hi ? OUT_HI : (sat_lo ? OUT_LO : rnd_sh[SAMPLE_WIDTH-1:0]);
            out_sat_reg    <= sat_hi || sat_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            m_reg         <= '0;
            age_reg       <= '0;
            rd_ptr_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            coef_ok_reg   <= 1'b0;
            hist_ok_reg   <= 1'b0;
            coef_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            m_reg         <= m_next;
            age_reg       <= age_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_vld_reg    <= issue;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= out_valid_next;
            if (issue)
            begin
                coef_ok_reg <= coef_vld_reg[m_reg];
                hist_ok_reg <= hist_ok;
            end
            if (do_coef)
            begin
                coef_vld_reg[c_addr] <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/fir_decimator.sv
// Channel   Dir  tdata (low bit up)                               tuser
// s_*       in   sample_value, coef_index, coef_value, zero pad   req_type
// m_*       out  output_sample                                    saturated
// APB       in   0x0 decim_factor, 0x4 taps_per_phase
//
// A coefficient write or a sample that completes no output is popped and leaves the MAC idle.
// A sample that completes an output runs one multiply-add per window entry (D*T entries)
// through the single shared multiplier, plus memory read, product and rounding stages.
// Commands wait in a two-entry queue while the MAC side is busy.
// Reset clears control state, coefficient valid bits and the history fill count; no sweep.
// The input side keeps accepting while the queue has room, also while a result waits.
module fir_decimator
    import fird_pkg::*;
#(
    parameter int MAX_DECIM          = DEF_MAX_DECIM,
    parameter int MAX_TAPS_PER_PHASE = DEF_MAX_TAPS,
    parameter int SAMPLE_WIDTH       = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH         = DEF_COEF_WIDTH,
    localparam int IN_BITS           = SAMPLE_WIDTH + IDX_W + COEF_WIDTH,
    localparam int IN_W              = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W             = ((SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // sample_value, coef_index, coef_value
    input  logic             s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // output_sample
    output logic             m_tuser,   // saturated
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CMD_W = IN_BITS + 2;

    logic [DF_W-1:0]  df_reg, df_next;
    logic [TPP_W-1:0] tpp_reg, tpp_next;
    fird_cfg_t        cfg;
    fird_reg_t        reg_sel;
    logic             cfg_wr;

    fird_qstat_t       q_stat;
    fird_bstat_t       bstat;
    logic              q_push, q_pop;
    logic [CMD_W-1:0]  q_in, q_out;
    logic [SAMPLE_WIDTH-1:0] out_sample;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = fird_reg_t'(paddr[2]);

    always_comb
    begin
        df_next  = df_reg;
        tpp_next = tpp_reg;
        prdata   = '0;
        case (reg_sel)
            REG_DECIM:
            begin
                prdata = 32'(df_reg);
                if (cfg_wr)
                begin
                    df_next = pwdata[DF_W-1:0];
                end
            end
            REG_TAPS:
            begin
                prdata = 32'(tpp_reg);
                if (cfg_wr)
                begin
                    tpp_next = pwdata[TPP_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            df_reg  <= DF_RESET;
            tpp_reg <= TPP_RESET;
        end
        else
        begin
            df_reg  <= df_next;
            tpp_reg <= tpp_next;
        end
    end

    assign cfg.decim_factor   = df_reg;
    assign cfg.taps_per_phase = tpp_reg;

    fird_front #(
        .MAX_DECIM    (MAX_DECIM),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .CMD_W        (CMD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_req    (s_tuser),
        .in_data   (s_tdata[IN_BITS-1:0]),
        .in_ready  (s_tready),
        .qstat     (q_stat),
        .push      (q_push),
        .push_data (q_in)
    );

    fird_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .qstat     (q_stat)
    );

    fird_back #(
        .MAX_DECIM          (MAX_DECIM),
        .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE),
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .COEF_WIDTH         (COEF_WIDTH),
        .CMD_W              (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (!q_stat.empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .bstat      (bstat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_sat    (m_tuser)
    );

    assign m_tdata = OUT_W'(out_sample);

`include "fir_decimator_assert.svh"

    `FIRD_ASSERT_IMP(a_full_blocks_input, q_stat.full, !s_tready, "input ready while queue full")
    `FIRD_ASSERT_NXT(a_accept_fills_queue, s_tvalid && s_tready, !q_stat.empty, "accepted word not queued")
    `FIRD_ASSERT_IMP(a_result_after_mac, $rose(m_tvalid), $past(bstat.finishing), "result without MAC pass")

endmodule
